// File: hw/rtl/m3i_pkg.sv
// shared types and constants for the 3x3 matrix inverse unit
package m3i_pkg;

  localparam int ENT_W       = 32;   // matrix entry width
  localparam int PROD_W      = 64;   // entry by entry product
  localparam int ADJ_W       = 66;   // signed 2x2 cofactor
  localparam int DET_W       = 100;  // exact determinant
  localparam int N_ENT       = 9;    // entries per matrix
  localparam int Q_STEPS     = 31;   // quotient bits below the saturation point
  localparam int QUEUE_DEPTH = 4;

  typedef logic signed [ENT_W-1:0]  ent_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ADJ_W-1:0]  adj_t;
  typedef logic signed [DET_W-1:0]  det_t;

  localparam ent_t ENT_MAX = 32'sh7fff_ffff;
  localparam ent_t ENT_MIN = 32'sh8000_0000;

  // cofactors in row order (not transposed) and the exact determinant
  typedef struct packed {
    adj_t [N_ENT-1:0] cof;
    det_t             det;
  } mat_item_t;

  typedef struct packed {
    ent_t [N_ENT-1:0] b;
    logic             invertible;
    ent_t             determinant;
  } result_t;

endpackage

// File: hw/rtl/m3i_front.sv
// front end: cofactors and exact determinant, four elastic stages
module m3i_front (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  m3i_pkg::ent_t [m3i_pkg::N_ENT-1:0]      mat_i,
  output logic                                    q_valid,
  input  logic                                    q_stall,
  output m3i_pkg::mat_item_t                      q_item
);
  import m3i_pkg::*;

  logic [3:0] v_r;
  logic [3:0] rdy;

  prod_t p0_r [N_ENT];
  prod_t p1_r [N_ENT];
  ent_t  e0_r [3];
  ent_t  e1_r [3];
  adj_t  cof_r [N_ENT];
  adj_t  cof2_r [N_ENT];
  adj_t  cof3_r [N_ENT];
  logic signed [ADJ_W-1:0] plo_r [3];
  logic signed [ADJ_W-2:0] phi_r [3];
  det_t  det_r;
  det_t  det_sum;

  assign rdy[3] = !v_r[3] || !q_stall;
  assign rdy[2] = !v_r[2] || rdy[3];
  assign rdy[1] = !v_r[1] || rdy[2];
  assign rdy[0] = !v_r[0] || rdy[1];
  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
      if (rdy[3]) v_r[3] <= v_r[2];
    end
  end

  // minor products and signed cofactors
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int R0 = (i == 0) ? 1 : 0;
      localparam int R1 = (i == 2) ? 1 : 2;
      localparam int C0 = (j == 0) ? 1 : 0;
      localparam int C1 = (j == 2) ? 1 : 2;
      localparam int K  = i * 3 + j;
      localparam bit NEG = ((i + j) % 2) != 0;
      adj_t t;

      assign t = ADJ_W'(p0_r[K]) - ADJ_W'(p1_r[K]);

      always_ff @(posedge clk) begin
        if (rdy[0]) begin
          p0_r[K] <= $signed(mat_i[R0*3+C0]) * $signed(mat_i[R1*3+C1]);
          p1_r[K] <= $signed(mat_i[R0*3+C1]) * $signed(mat_i[R1*3+C0]);
        end
        if (rdy[1]) begin
          cof_r[K] <= NEG ? -t : t;
        end
      end
    end
  end

  // first row times its cofactors, cofactor split in two halves
  for (genvar j = 0; j < 3; j++) begin : g_det
    logic signed [33:0] lo;
    logic signed [32:0] hi;

    assign lo = {1'b0, cof_r[j][32:0]};
    assign hi = cof_r[j][ADJ_W-1:33];

    always_ff @(posedge clk) begin
      if (rdy[0]) e0_r[j] <= mat_i[j];
      if (rdy[1]) e1_r[j] <= e0_r[j];
      if (rdy[2]) begin
        plo_r[j] <= e1_r[j] * lo;
        phi_r[j] <= e1_r[j] * hi;
      end
    end
  end

  always_comb begin
    det_sum = '0;
    for (int j = 0; j < 3; j++) begin
      det_sum = det_sum + (DET_W'(phi_r[j]) <<< 33) + DET_W'(plo_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) cof2_r <= cof_r;
    if (rdy[3]) begin
      cof3_r <= cof2_r;
      det_r  <= det_sum;
    end
  end

  assign q_valid = v_r[3];

  always_comb begin
    for (int k = 0; k < N_ENT; k++) begin
      q_item.cof[k] = cof3_r[k];
    end
    q_item.det = det_r;
  end

endmodule

// File: hw/rtl/m3i_fifo.sv
// short request queue between the front end and the divider back end
module m3i_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_stall,
  input  m3i_pkg::mat_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_stall,
  output m3i_pkg::mat_item_t pop_item
);
  import m3i_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  mat_item_t       slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CNTW-1:0] cnt_r;
  logic            do_push;
  logic            do_pop;

  assign push_stall = (cnt_r == CNTW'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop_valid && !pop_stall;
  assign pop_item   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + PW'(1);
      if (do_push && !do_pop) cnt_r <= cnt_r + CNTW'(1);
      else if (!do_push && do_pop) cnt_r <= cnt_r - CNTW'(1);
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> cnt_r == $past(cnt_r) + CNTW'(1))
    else $error("queue count did not follow a push");
`endif

endmodule

// File: hw/rtl/m3i_back.sv
// back end: magnitudes, saturation check, restoring divide per entry, output register
module m3i_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_stall,
  input  m3i_pkg::mat_item_t pop_item,
  output logic               out_valid,
  input  logic               out_stall,
  output m3i_pkg::result_t   res
);
  import m3i_pkg::*;

  localparam int NUM_W = ADJ_W + 2 * FRAC_BITS;
  localparam int LIM_W = DET_W + Q_STEPS;
  localparam int CW    = (NUM_W > LIM_W) ? NUM_W : LIM_W;

  // magnitude stage
  logic             v0_r;
  logic [ADJ_W-1:0] amag0_r [N_ENT];
  logic [N_ENT-1:0] aneg0_r;
  logic [DET_W-1:0] dmag0_r;
  logic             dneg0_r;
  logic             dzero0_r;

  // divide stages, index s holds the state before step s
  logic [Q_STEPS:0]    vs_r;
  logic [Q_STEPS:0]    rdy_s;
  logic [CW-1:0]       rem_r [Q_STEPS][N_ENT];
  logic [Q_STEPS-1:0]  q_r   [Q_STEPS+1][N_ENT];
  logic [N_ENT-1:0]    ovf_r [Q_STEPS+1];
  logic [N_ENT-1:0]    neg_r [Q_STEPS+1];
  logic [DET_W-1:0]    dm_r  [Q_STEPS];
  logic                dz_r  [Q_STEPS+1];
  ent_t                dt_r  [Q_STEPS+1];

  logic    vo_r;
  result_t res_r;
  logic    rdy_out;
  logic    rdy0;

  assign rdy_out = !vo_r || !out_stall;
  assign rdy_s[Q_STEPS] = !vs_r[Q_STEPS] || rdy_out;
  for (genvar s = 0; s < Q_STEPS; s++) begin : g_rdy
    assign rdy_s[s] = !vs_r[s] || rdy_s[s+1];
  end
  assign rdy0 = !v0_r || rdy_s[0];
  assign pop_stall = !rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      vs_r <= '0;
      vo_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= pop_valid;
      if (rdy_s[0]) vs_r[0] <= v0_r;
      for (int s = 0; s < Q_STEPS; s++) begin
        if (rdy_s[s+1]) vs_r[s+1] <= vs_r[s];
      end
      if (rdy_out) vo_r <= vs_r[Q_STEPS];
    end
  end

  // magnitudes; lane k takes the transposed cofactor
  for (genvar k = 0; k < N_ENT; k++) begin : g_mag
    localparam int T = (k % 3) * 3 + (k / 3);
    adj_t c;

    assign c = pop_item.cof[T];

    always_ff @(posedge clk) begin
      if (rdy0) begin
        aneg0_r[k] <= c[ADJ_W-1];
        amag0_r[k] <= c[ADJ_W-1] ? ADJ_W'(-c) : ADJ_W'(c);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      dneg0_r  <= pop_item.det[DET_W-1];
      dmag0_r  <= pop_item.det[DET_W-1] ? DET_W'(-pop_item.det) : DET_W'(pop_item.det);
      dzero0_r <= (pop_item.det == '0);
    end
  end

  // saturation check and determinant output
  logic [CW-1:0]    lim;
  logic [DET_W-1:0] dhi;
  logic [ENT_W-1:0] dlow;
  ent_t             dsat;

  assign lim  = CW'(dmag0_r) << Q_STEPS;
  assign dhi  = dmag0_r >> (2 * FRAC_BITS);
  assign dlow = {1'b0, dhi[ENT_W-2:0]};

  always_comb begin
    if (|dhi[DET_W-1:ENT_W-1]) begin
      dsat = dneg0_r ? ENT_MIN : ENT_MAX;
    end else begin
      dsat = dneg0_r ? ent_t'(-dlow) : ent_t'(dlow);
    end
  end

  for (genvar k = 0; k < N_ENT; k++) begin : g_lim
    logic [CW-1:0] num;

    assign num = CW'(amag0_r[k]) << (2 * FRAC_BITS);

    always_ff @(posedge clk) begin
      if (rdy_s[0]) begin
        rem_r[0][k] <= num;
        q_r[0][k]   <= '0;
        ovf_r[0][k] <= (num >= lim);
        neg_r[0][k] <= aneg0_r[k] ^ dneg0_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_s[0]) begin
      dm_r[0] <= dmag0_r;
      dz_r[0] <= dzero0_r;
      dt_r[0] <= dsat;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar s = 0; s < Q_STEPS; s++) begin : g_step
    localparam int SH = Q_STEPS - 1 - s;
    logic [CW-1:0] dsh;

    assign dsh = CW'(dm_r[s]) << SH;

    for (genvar k = 0; k < N_ENT; k++) begin : g_lane
      logic ge;

      assign ge = (rem_r[s][k] >= dsh);

      always_ff @(posedge clk) begin
        if (rdy_s[s+1]) begin
          q_r[s+1][k] <= {q_r[s][k][Q_STEPS-2:0], ge};
        end
      end

      if (s < Q_STEPS - 1) begin : g_rem
        always_ff @(posedge clk) begin
          if (rdy_s[s+1]) begin
            rem_r[s+1][k] <= ge ? (rem_r[s][k] - dsh) : rem_r[s][k];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rdy_s[s+1]) begin
        ovf_r[s+1] <= ovf_r[s];
        neg_r[s+1] <= neg_r[s];
        dz_r[s+1]  <= dz_r[s];
        dt_r[s+1]  <= dt_r[s];
      end
    end

    if (s < Q_STEPS - 1) begin : g_dm
      always_ff @(posedge clk) begin
        if (rdy_s[s+1]) dm_r[s+1] <= dm_r[s];
      end
    end
  end

  // sign, saturation and singular case
  result_t res_nxt;
  logic [ENT_W-1:0] qq [N_ENT];

  always_comb begin
    for (int k = 0; k < N_ENT; k++) begin
      qq[k] = {1'b0, q_r[Q_STEPS][k]};
      if (dz_r[Q_STEPS]) begin
        res_nxt.b[k] = '0;
      end else if (ovf_r[Q_STEPS][k]) begin
        res_nxt.b[k] = neg_r[Q_STEPS][k] ? ENT_MIN : ENT_MAX;
      end else begin
        res_nxt.b[k] = neg_r[Q_STEPS][k] ? ent_t'(-qq[k]) : ent_t'(qq[k]);
      end
    end
    res_nxt.invertible  = !dz_r[Q_STEPS];
    res_nxt.determinant = dz_r[Q_STEPS] ? '0 : dt_r[Q_STEPS];
  end

  always_ff @(posedge clk) begin
    if (rdy_out) res_r <= res_nxt;
  end

  assign out_valid = vo_r;
  assign res       = res_r;

`ifndef NO_ASSERTIONS
  a_pop_enters: assert property (@(posedge clk) disable iff (!rst_n)
    pop_valid && !pop_stall |=> v0_r)
    else $error("accepted request missing from magnitude stage");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r && !res_r.invertible |-> res_r.b == '0 && res_r.determinant == '0)
    else $error("singular result carries nonzero data");
`endif

endmodule

// File: hw/rtl/matrix3_inverse_unit.sv
// top level of the 3x3 fixed-point matrix inverse unit
//
// usage
// - input channel: one request per accepted edge (in_valid high, in_stall low),
//   nine signed fixed-point entries in_a11 .. in_a33 by row
// - result channel: one result per request, in order, accepted when
//   out_valid is high and out_stall is low
// - result: inverse entries out_b11 .. out_b33, truncated toward zero and
//   saturated, out_invertible, and the saturated out_determinant; a singular
//   matrix gives all zeros with out_invertible low
// - stages: 4 front, 1 queue and 34 back, the first loaded at the accepting edge
// - throughput: one request per cycle while in_stall is low; the 31 quotient
//   bits come from a chain of 31 restoring compare/subtract stages, one bit
//   per stage and entry
// - reset: synchronous, active low; empties every stage and the queue
// - stall: out_stall freezes the back stages, the four-entry queue absorbs
//   the front stages, then in_stall rises; a waiting result does not block
//   new requests while any stage has a free slot
module matrix3_inverse_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  m3i_pkg::ent_t       in_a11,
  input  m3i_pkg::ent_t       in_a12,
  input  m3i_pkg::ent_t       in_a13,
  input  m3i_pkg::ent_t       in_a21,
  input  m3i_pkg::ent_t       in_a22,
  input  m3i_pkg::ent_t       in_a23,
  input  m3i_pkg::ent_t       in_a31,
  input  m3i_pkg::ent_t       in_a32,
  input  m3i_pkg::ent_t       in_a33,
  output logic                out_valid,
  input  logic                out_stall,
  output m3i_pkg::ent_t       out_b11,
  output m3i_pkg::ent_t       out_b12,
  output m3i_pkg::ent_t       out_b13,
  output m3i_pkg::ent_t       out_b21,
  output m3i_pkg::ent_t       out_b22,
  output m3i_pkg::ent_t       out_b23,
  output m3i_pkg::ent_t       out_b31,
  output m3i_pkg::ent_t       out_b32,
  output m3i_pkg::ent_t       out_b33,
  output logic                out_invertible,
  output m3i_pkg::ent_t       out_determinant
);
  import m3i_pkg::*;

  // entries gathered row by row, index is row * 3 + column
  ent_t [N_ENT-1:0] mat;

  // queue handshake between front and back
  logic      fq_valid;
  logic      fq_stall;
  mat_item_t fq_item;
  logic      bq_valid;
  logic      bq_stall;
  mat_item_t bq_item;

  result_t res;

  assign mat[0] = in_a11;
  assign mat[1] = in_a12;
  assign mat[2] = in_a13;
  assign mat[3] = in_a21;
  assign mat[4] = in_a22;
  assign mat[5] = in_a23;
  assign mat[6] = in_a31;
  assign mat[7] = in_a32;
  assign mat[8] = in_a33;

  // cofactors and exact determinant
  m3i_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mat_i    (mat),
    .q_valid  (fq_valid),
    .q_stall  (fq_stall),
    .q_item   (fq_item)
  );

  // decouples the front from back-end stalls
  m3i_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_stall (fq_stall),
    .push_item  (fq_item),
    .pop_valid  (bq_valid),
    .pop_stall  (bq_stall),
    .pop_item   (bq_item)
  );

  // per-entry division, saturation and output register
  m3i_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (bq_valid),
    .pop_stall (bq_stall),
    .pop_item  (bq_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign out_b11         = res.b[0];
  assign out_b12         = res.b[1];
  assign out_b13         = res.b[2];
  assign out_b21         = res.b[3];
  assign out_b22         = res.b[4];
  assign out_b23         = res.b[5];
  assign out_b31         = res.b[6];
  assign out_b32         = res.b[7];
  assign out_b33         = res.b[8];
  assign out_invertible  = res.invertible;
  assign out_determinant = res.determinant;

endmodule

// File: tb/sv/m3i_checker.sv
// result checker for the 3x3 matrix inverse unit: predicts each inverse and compares
`timescale 1ns / 1ps
module m3i_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  m3i_pkg::ent_t in_a [9],
  input  logic          out_valid,
  input  logic          out_stall,
  input  m3i_pkg::ent_t out_b [9],
  input  logic          out_invertible,
  input  m3i_pkg::ent_t out_determinant,
  output int            err_count,
  output int            pending
);
  import m3i_pkg::*;

  localparam int FRAC = 16;

  typedef struct {
    ent_t b [9];
    logic inv;
    ent_t det;
  } inverse_t;

  inverse_t inverse_q[$];

  function automatic ent_t clamp32(logic signed [255:0] v);
    if (v > 256'sd2147483647) return ENT_MAX;
    if (v < -256'sd2147483648) return ENT_MIN;
    return ent_t'(v[31:0]);
  endfunction

  function automatic inverse_t invert(ent_t a [9]);
    inverse_t r;
    logic signed [255:0] m [3][3];
    logic signed [255:0] c [3][3];
    logic signed [255:0] d, dm, num, q;
    int r0, r1, c0, c1;
    for (int k = 0; k < 9; k++) m[k/3][k%3] = a[k];
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        r0 = (i == 0) ? 1 : 0; r1 = (i == 2) ? 1 : 2;
        c0 = (j == 0) ? 1 : 0; c1 = (j == 2) ? 1 : 2;
        c[i][j] = m[r0][c0] * m[r1][c1] - m[r0][c1] * m[r1][c0];
        if ((i + j) % 2 == 1) c[i][j] = -c[i][j];
      end
    d = m[0][0] * c[0][0] + m[0][1] * c[0][1] + m[0][2] * c[0][2];
    if (d == 0) begin
      foreach (r.b[k]) r.b[k] = '0;
      r.inv = 1'b0;
      r.det = '0;
      return r;
    end
    dm = (d < 0) ? -d : d;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        // transposed cofactor, magnitude division truncates toward zero
        num = ((c[j][i] < 0) ? -c[j][i] : c[j][i]) <<< (2 * FRAC);
        q = num / dm;
        if ((c[j][i] < 0) != (d < 0)) q = -q;
        r.b[i*3+j] = clamp32(q);
      end
    r.inv = 1'b1;
    q = dm >>> (2 * FRAC);
    r.det = clamp32((d < 0) ? -q : q);
    return r;
  endfunction

  assign pending = inverse_q.size();

  initial err_count = 0;

  always @(posedge clk) begin
    inverse_t e;
    if (rst_n && in_valid && !in_stall) inverse_q.push_back(invert(in_a));
    if (rst_n && out_valid && !out_stall) begin
      if (inverse_q.size() == 0) begin
        $display("%0t: unexpected result", $time);
        err_count++;
      end else begin
        e = inverse_q.pop_front();
        for (int k = 0; k < 9; k++)
          if (out_b[k] !== e.b[k]) begin
            $display("%0t: b%0d%0d expected %0d actual %0d", $time, k/3+1, k%3+1,
                     e.b[k], out_b[k]);
            err_count++;
          end
        if (out_invertible !== e.inv) begin
          $display("%0t: invertible expected %0b actual %0b", $time, e.inv,
                   out_invertible);
          err_count++;
        end
        if (out_determinant !== e.det) begin
          $display("%0t: determinant expected %0d actual %0d", $time, e.det,
                   out_determinant);
          err_count++;
        end
      end
    end
  end
endmodule

// File: tb/sv/testbench.sv
// stimulus and verdict for the 3x3 matrix inverse unit
`timescale 1ns / 1ps
module testbench;
  import m3i_pkg::*;

  localparam int N_RANDOM  = 1000;
  localparam int CYC_LIMIT = 400000;
  localparam int DRAIN     = 60;     // extra wait after the checker has no pending results

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, out_invertible;
  ent_t a [9];
  ent_t b [9];
  ent_t out_determinant;
  int   err_count, pending, cycles;
  int   rx_wait;
  bit   sending_done, hold_off;

  matrix3_inverse_unit dut (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_a11(a[0]), .in_a12(a[1]), .in_a13(a[2]),
    .in_a21(a[3]), .in_a22(a[4]), .in_a23(a[5]),
    .in_a31(a[6]), .in_a32(a[7]), .in_a33(a[8]),
    .out_valid, .out_stall,
    .out_b11(b[0]), .out_b12(b[1]), .out_b13(b[2]),
    .out_b21(b[3]), .out_b22(b[4]), .out_b23(b[5]),
    .out_b31(b[6]), .out_b32(b[7]), .out_b33(b[8]),
    .out_invertible, .out_determinant
  );

  m3i_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_a(a),
    .out_valid, .out_stall, .out_b(b), .out_invertible, .out_determinant,
    .err_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // one Q16.16 value: 1.0 in fixed point
  localparam ent_t ONE = 32'sh0001_0000;

  // random entry with a spread of magnitudes so both small and saturating cases occur
  function automatic ent_t rand_entry();
    case ($urandom_range(0, 5))
      0: return ent_t'($urandom);
      1: return ent_t'($signed($urandom_range(0, 32'h3ffff)) - 32'sh2_0000);
      2: return ent_t'($signed($urandom_range(0, 255)) - 128);
      3: return ($urandom_range(0, 1)) ? ENT_MAX : ENT_MIN;
      4: return ent_t'($signed($urandom_range(0, 32'h7ff_ffff)) - 32'sh400_0000);
      default: return ent_t'($signed($urandom_range(0, 16)) - 8) <<< 16;
    endcase
  endfunction

  // hands one request over and holds it until accepted
  task automatic send_matrix(input ent_t m [9]);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int k = 0; k < 9; k++) a[k] <= m[k];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // directed corners then random matrices, with singular ones mixed in
  initial begin
    ent_t m [9];
    in_valid = 1'b0;
    foreach (a[k]) a[k] = '0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (m[k]) m[k] = '0;
    send_matrix(m);                                    // all zero, singular
    foreach (m[k]) m[k] = (k % 4 == 0) ? ONE : '0;
    send_matrix(m);                                    // identity
    foreach (m[k]) m[k] = (k % 4 == 0) ? -ONE : '0;
    send_matrix(m);                                    // negative identity
    foreach (m[k]) m[k] = (k % 4 == 0) ? 32'sd1 : '0;
    send_matrix(m);                                    // tiny det, huge inverse
    foreach (m[k]) m[k] = (k % 4 == 0) ? ENT_MAX : '0;
    send_matrix(m);                                    // determinant saturates high
    foreach (m[k]) m[k] = (k % 4 == 0) ? ENT_MIN : '0;
    send_matrix(m);                                    // determinant saturates low
    foreach (m[k]) m[k] = ENT_MAX;
    send_matrix(m);                                    // equal rows, singular
    foreach (m[k]) m[k] = ENT_MIN;
    send_matrix(m);
    foreach (m[k]) m[k] = (k % 2 == 0) ? ENT_MAX : ENT_MIN;
    send_matrix(m);
    foreach (m[k]) m[k] = ent_t'(32'h5555_5555 ^ {32{k[0]}});
    send_matrix(m);
    foreach (m[k]) m[k] = ent_t'((k + 1) <<< 16);      // 1..9 rows, singular
    send_matrix(m);
    foreach (m[k]) m[k] = '0;
    m[0] = 32'sd1; m[4] = 32'sd2; m[8] = ONE;          // invertible, det truncates to 0
    send_matrix(m);
    m[0] = 32'sh0002_0000; m[1] = ONE; m[2] = '0;
    m[3] = ONE; m[4] = 32'sh0003_0000; m[5] = -ONE;
    m[6] = '0; m[7] = ONE; m[8] = 32'sh0004_0000;
    send_matrix(m);
    for (int n = 0; n < N_RANDOM; n++) begin
      foreach (m[k]) m[k] = rand_entry();
      if ($urandom_range(0, 7) == 0) for (int k = 0; k < 3; k++) m[6+k] = m[k];
      else if ($urandom_range(0, 9) == 0) begin
        for (int k = 0; k < 3; k++) m[3+k] = -m[k];
      end
      send_matrix(m);
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  // one long hold-off early so the pipe and queue back up
  initial begin
    out_stall = 1'b1;
    @(posedge rst_n);
    repeat (30) @(posedge clk);
    hold_off <= 1'b1;
    repeat (600) @(posedge clk);
    hold_off <= 1'b0;
  end

  // receiver sometimes draws a random wait before taking the next result
  always @(posedge clk) begin
    if (!rst_n || hold_off) begin
      out_stall <= 1'b1;
      rx_wait   <= $urandom_range(0, 17);
    end else if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait   <= rx_wait - 1;
    end else if (out_valid && !out_stall) begin
      rx_wait   <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // verdict and the cycle limit
  initial begin
    cycles = 0;
    sending_done = 1'b0;
    hold_off = 1'b0;
    while (!(sending_done && pending == 0) && cycles < CYC_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    if (cycles >= CYC_LIMIT) begin
      $display("testbench: done, errors");
    end else begin
      repeat (DRAIN) @(posedge clk);
      if (err_count == 0) $display("testbench: done, clean");
      else $display("testbench: done, errors");
    end
    $finish;
  end
endmodule

// File: files.f
hw/rtl/m3i_pkg.sv
hw/rtl/m3i_front.sv
hw/rtl/m3i_fifo.sv
hw/rtl/m3i_back.sv
hw/rtl/matrix3_inverse_unit.sv
tb/sv/m3i_checker.sv
tb/sv/testbench.sv
